[src/ttmh_pkg.sv]
// shared types and constants of the travel time mean and histogram block
`default_nettype none

package ttmh_pkg;

  localparam int unsigned TT_W      = 10;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned MEAN_W    = 26;
  localparam int unsigned SHARE_W   = 17;
  localparam int unsigned RATE_W    = 17;
  localparam int unsigned TOTAL_W   = 32;
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned CFG_IDX_W = 1;

  // mean * count + sample stays below 2^58
  localparam int unsigned DIVD_W  = 58;
  localparam int unsigned DIVR_W  = 33;
  localparam int unsigned REM_W   = DIVR_W + 1;
  localparam int unsigned PRODB_W = TT_W + RATE_W;
  localparam int unsigned BLEND_W = MEAN_W + FRAC_W + 1;
  localparam int unsigned STEP_W  = $clog2(DIVD_W);

  localparam logic [RATE_W-1:0]  RATE_ONE  = RATE_W'(65536);
  localparam logic [SHARE_W-1:0] SHARE_MAX = SHARE_W'(65536);
  localparam logic [MEAN_W-1:0]  MEAN_MAX  = MEAN_W'(1023 * 65536);
  localparam logic [RATE_W-1:0]  RATE_RST  = RATE_W'(6554);

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    MODE_CUMUL = 1'b0,
    MODE_BLEND = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COST_MODE = 1'b0,
    REG_EWMA_RATE = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [TT_W-1:0] travel_time;
  } in_item_t;

  typedef struct packed {
    logic [MEAN_W-1:0]  mean_q16;
    logic [SHARE_W-1:0] share_q16;
    logic               no_samples;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic clear_step;
    logic ram_read;
    logic mul_en;
    logic div_load;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic is_ewma;
    logic total_zero;
    logic div_last;
    logic clear_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[src/ttmh_stream_if.sv]
// valid/ready channel carrying one item payload
`default_nettype none

interface ttmh_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

[src/ttmh_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module ttmh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/ttmh_ctrl.sv]
// controller state machine sequencing clear, read, multiply, divide and output
`default_nettype none

module ttmh_ctrl import ttmh_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        // empty query needs no division
        if (stat_i.is_query && stat_i.total_zero) state_d = ST_DONE;
        else                                      state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat_i.is_ewma) state_d = ST_DONE;
        else                state_d = ST_DIV;
      end
      ST_DIV: begin
        if (stat_i.div_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    in_ready_o       = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_READ: begin
        cmd_o.ram_read = 1'b1;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_DONE: begin
        cmd_o.finish = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/ttmh_dp.sv]
// datapath: config registers, mean and count state, bin store, multiplier and divider
`default_nettype none

module ttmh_dp import ttmh_pkg::*; #(
  parameter int unsigned NUM_BINS = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire in_item_t             in_item_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output out_item_t                 out_item_o,
  input  wire dp_cmd_t              cmd_i,
  output dp_stat_t                  stat_o
);

  localparam int unsigned BIN_W = $clog2(NUM_BINS);
  localparam int unsigned EXT_W = 17;

  // configuration
  mode_e             cost_mode_q;
  logic [RATE_W-1:0] ewma_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_mode_q <= MODE_CUMUL;
      ewma_rate_q <= RATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_COST_MODE: cost_mode_q <= mode_e'(cfg_wdata_i[0]);
        REG_EWMA_RATE: ewma_rate_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // item capture, bins past the store fold into the last one
  cmd_e             cmd_q;
  logic [TT_W-1:0]  tt_q;
  logic [BIN_W-1:0] bin_q;
  logic [EXT_W-1:0] tt_ext;
  logic [BIN_W-1:0] in_bin;

  assign tt_ext = EXT_W'(in_item_i.travel_time);
  assign in_bin = (tt_ext >= EXT_W'(NUM_BINS)) ? BIN_W'(NUM_BINS - 1) : tt_ext[BIN_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q <= in_item_i.cmd;
      tt_q  <= in_item_i.travel_time;
      bin_q <= in_bin;
    end
  end

  logic is_query, is_ewma, is_record;
  assign is_query  = (cmd_q == CMD_QUERY);
  assign is_ewma   = !is_query && (cost_mode_q == MODE_BLEND);
  assign is_record = !is_query && (cost_mode_q == MODE_CUMUL);

  // running state
  logic [MEAN_W-1:0]  mean_q;
  logic [TOTAL_W-1:0] total_q;
  logic               total_zero;
  assign total_zero = (total_q == '0);

  // bin store and its clearing sweep
  logic [BIN_W-1:0]   clr_q;
  logic [TOTAL_W-1:0] count;
  logic [TOTAL_W-1:0] count_inc;
  logic               ram_we;
  logic [BIN_W-1:0]   ram_waddr;
  logic [TOTAL_W-1:0] ram_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_q <= clr_q + BIN_W'(1);
    end
  end

  assign count_inc = (count == '1) ? count : count + TOTAL_W'(1);
  assign ram_we    = cmd_i.clear_step || (cmd_i.finish && is_record);
  assign ram_waddr = cmd_i.clear_step ? clr_q : bin_q;
  assign ram_wdata = cmd_i.clear_step ? '0 : count_inc;

  ttmh_ram #(
    .WIDTH (TOTAL_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.ram_read),
    .raddr_i (bin_q),
    .rdata_o (count)
  );

  // multiply stage
  logic [RATE_W-1:0]  rate_clamp;
  logic [RATE_W-1:0]  rate_inv;
  logic [TOTAL_W-1:0] mul_b;
  logic [DIVD_W-1:0]  prod_a_q;
  logic [PRODB_W-1:0] prod_b_q;

  assign rate_clamp = (ewma_rate_q > RATE_ONE) ? RATE_ONE : ewma_rate_q;
  assign rate_inv   = RATE_ONE - rate_clamp;
  assign mul_b      = is_ewma ? TOTAL_W'(rate_inv) : total_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_a_q <= DIVD_W'(mean_q) * DIVD_W'(mul_b);
      prod_b_q <= PRODB_W'(tt_q) * PRODB_W'(rate_clamp);
    end
  end

  // divider operands, ewma blend bypasses the divider through the quotient register
  logic [DIVD_W-1:0]  divd_rec, divd_qry;
  logic [BLEND_W-1:0] blend_sum;
  logic [MEAN_W-1:0]  blend;

  assign divd_rec  = prod_a_q + DIVD_W'({tt_q, {FRAC_W{1'b0}}});
  assign divd_qry  = DIVD_W'({count, {FRAC_W{1'b0}}});
  assign blend_sum = BLEND_W'(prod_a_q) + BLEND_W'({prod_b_q, {FRAC_W{1'b0}}});
  assign blend     = blend_sum[FRAC_W +: MEAN_W];

  // restoring divider, one quotient bit per cycle
  logic [DIVR_W-1:0] rem_q;
  logic [DIVD_W-1:0] quo_q;
  logic [DIVR_W-1:0] divr_q;
  logic [STEP_W-1:0] step_q;
  logic [REM_W-1:0]  shifted, diff;
  logic              fits;

  assign shifted = {rem_q, quo_q[DIVD_W-1]};
  assign fits    = (shifted >= REM_W'(divr_q));
  assign diff    = shifted - REM_W'(divr_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q  <= '0;
      step_q <= STEP_W'(DIVD_W - 1);
      if (is_query) begin
        quo_q  <= divd_qry;
        divr_q <= DIVR_W'(total_q);
      end else if (is_ewma) begin
        quo_q  <= DIVD_W'(blend);
        divr_q <= DIVR_W'(total_q);
      end else begin
        quo_q  <= divd_rec;
        divr_q <= DIVR_W'(total_q) + DIVR_W'(1);
      end
    end else if (cmd_i.div_step) begin
      rem_q  <= fits ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
      quo_q  <= {quo_q[DIVD_W-2:0], fits};
      step_q <= step_q - STEP_W'(1);
    end
  end

  // result and commit
  out_item_t          res;
  logic               out_valid_q;
  out_item_t          out_item_q;
  logic               out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    res            = '0;
    res.mean_q16   = is_query ? mean_q : quo_q[MEAN_W-1:0];
    res.no_samples = is_query && total_zero;
    if (is_query && !total_zero) begin
      res.share_q16 = (quo_q > DIVD_W'(SHARE_MAX)) ? SHARE_MAX : quo_q[SHARE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        mean_q      <= res.mean_q16;
        out_valid_q <= 1'b1;
        if (is_record && (total_q != '1)) begin
          total_q <= total_q + TOTAL_W'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign stat_o.is_query   = is_query;
  assign stat_o.is_ewma    = is_ewma;
  assign stat_o.total_zero = total_zero;
  assign stat_o.div_last   = (step_q == '0);
  assign stat_o.clear_last = (clr_q == BIN_W'(NUM_BINS - 1));
  assign stat_o.out_free   = out_free;

endmodule

`default_nettype wire

[src/travel_time_mean_histogram.sv]
// top level of the travel time mean and histogram block
//
//   channel | dir | payload                               | handshake
//   in_ch   | in  | cmd, travel_time                      | valid/ready
//   out_ch  | out | mean_q16, share_q16, no_samples       | valid/ready
//   cfg     | in  | cfg_idx_i, cfg_wdata_i                | cfg_we_i, no wait
//
// a record insert or a non-empty query passes read, multiply, load and the
// 58-step restoring divider before its result; ewma inserts finish after load,
// empty queries after multiply. new items are taken only after the result is
// registered. after reset the bin store is swept to zero bin by bin, no item
// is taken meanwhile; configuration writes are taken at any time.
// a stalled output holds its result; the block waits in its last step for it.
`default_nettype none

module travel_time_mean_histogram import ttmh_pkg::*; #(
  parameter int unsigned NUM_BINS = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  ttmh_stream_if.sink               in_ch,
  ttmh_stream_if.source             out_ch
);

  dp_cmd_t   dp_cmd;
  dp_stat_t  dp_stat;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;

  ttmh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  ttmh_dp #(
    .NUM_BINS (NUM_BINS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_ch.data),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

endmodule

`default_nettype wire

[src/ttmh_checker.sv]
// port level checks of the travel time mean and histogram block, bound to the top
`default_nettype none

module ttmh_assert import ttmh_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_i,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire out_item_t out_item_i
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("output item changed while stalled");

  // an empty query never reports a share
  a_empty_share: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.no_samples |-> out_item_i.share_q16 == '0)
    else $error("share reported with no samples");

  a_share_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_item_i.share_q16 <= SHARE_MAX)
    else $error("share above one");

  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_item_i.mean_q16 <= MEAN_MAX)
    else $error("mean out of range");

  // one item at a time: the input closes right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while busy");

endmodule

bind travel_time_mean_histogram ttmh_assert u_ttmh_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_item_i  (out_ch.data)
);

`default_nettype wire
